// ----- hw/rtl/gdc_pkg.sv -----
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared types and constants for the goal distance trajectory cost block.
// ----------------------------------------------------------------------------
package gdc_pkg;

    // default trajectory length in points
    localparam int STEPS_DEF = 56;

    // field and datapath widths
    localparam int POS_W   = 32;
    localparam int DIFF_W  = 33;
    localparam int SQ_W    = 67;
    localparam int ROOT_W  = 35;
    localparam int DIST_W  = 33;
    localparam int SUM_W   = 40;
    localparam int COST_W  = 63;
    localparam int POW_W   = 3;
    localparam int ACC_W   = 128;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [COST_W-1:0] COST_ONE = COST_W'(65536);

    // sum queue depth
    localparam int QDEPTH = 2;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ENABLE = 3'd0,
        REG_GOAL_X = 3'd1,
        REG_GOAL_Y = 3'd2,
        REG_ROBOT_X = 3'd3,
        REG_ROBOT_Y = 3'd4,
        REG_WEIGHT = 3'd5,
        REG_POWER  = 3'd6,
        REG_RADIUS = 3'd7
    } cfg_idx_t;

    // front states
    typedef enum logic [2:0] {
        F_IDLE,
        F_MX,
        F_MY,
        F_ADD,
        F_SQRT,
        F_ACC
    } front_state_t;

    // back states
    typedef enum logic [3:0] {
        B_IDLE,
        B_G0,
        B_G1,
        B_G2,
        B_G3,
        B_QM,
        B_QEND,
        B_POW,
        B_OUT
    } back_state_t;

    // absolute difference of two signed Q16.16 values
    function automatic logic [DIFF_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                   input logic [POS_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        begin
            d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
            abs_diff = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        end
    endfunction

endpackage

// ----- hw/rtl/gdc_front.sv -----
// ----------------------------------------------------------------------------
// gdc_front
// Accepts points, forms distance to goal by a bit-serial square root and
// gathers the per-trajectory sum, pushed to the queue at the last point.
// ----------------------------------------------------------------------------
module gdc_front
    import gdc_pkg::*;
#(
    parameter int STEPS = STEPS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [POS_W-1:0]  point_x,
    input  logic [POS_W-1:0]  point_y,
    input  logic [POS_W-1:0]  goal_x,
    input  logic [POS_W-1:0]  goal_y,
    output logic              push,
    output logic [SUM_W-1:0]  push_sum,
    input  logic              q_full
);

    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int REM_W = ROOT_W + 2;
    localparam int OP_W  = 2 * ROOT_W;

    front_state_t state_reg, state_next;

    logic [DIFF_W-1:0]  dx_reg, dy_reg;
    logic [2*DIFF_W-1:0] p_reg;
    logic [SQ_W-1:0]    s_reg;
    logic [OP_W-1:0]    op_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [5:0]         bit_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]   sum_reg;

    logic [REM_W-1:0]   rem_sh, trial;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_sat;
    logic               last_pt;

    // square root step and saturating accumulate
    assign rem_sh  = {rem_reg[REM_W-3:0], op_reg[OP_W-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign sum_add = {1'b0, sum_reg} + (SUM_W+1)'(root_reg[DIST_W-1:0]);
    assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    assign last_pt = (cnt_reg == CNT_W'(STEPS - 1));
    assign push_sum = sum_sat;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid) state_next = F_MX;
            F_MX:   state_next = F_MY;
            F_MY:   state_next = F_ADD;
            F_ADD:  state_next = F_SQRT;
            F_SQRT: if (bit_reg == 6'd0) state_next = F_ACC;
            F_ACC:  if (!last_pt || !q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = (state_reg == F_IDLE);
        push     = (state_reg == F_ACC) && last_pt && !q_full;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_ACC)
            begin
                if (!last_pt)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    sum_reg <= sum_sat;
                end
                else if (!q_full)
                begin
                    cnt_reg <= '0;
                    sum_reg <= '0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                dx_reg <= abs_diff(point_x, goal_x);
                dy_reg <= abs_diff(point_y, goal_y);
            end
            F_MX: p_reg <= dx_reg * dx_reg;
            F_MY:
            begin
                s_reg <= SQ_W'(p_reg);
                p_reg <= dy_reg * dy_reg;
            end
            F_ADD:
            begin
                op_reg   <= OP_W'(s_reg + SQ_W'(p_reg));
                rem_reg  <= '0;
                root_reg <= '0;
                bit_reg  <= 6'(ROOT_W - 1);
            end
            F_SQRT:
            begin
                op_reg  <= {op_reg[OP_W-3:0], 2'b00};
                bit_reg <= bit_reg - 1'b1;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- hw/rtl/gdc_queue.sv -----
// ----------------------------------------------------------------------------
// gdc_queue
// Short queue of finished trajectory sums between front and back.
// ----------------------------------------------------------------------------
module gdc_queue
    import gdc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [SUM_W-1:0] push_sum,
    output logic             full,
    input  logic             pop,
    output logic [SUM_W-1:0] pop_sum,
    output logic             empty
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    logic [SUM_W-1:0] mem [QDEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [PW:0]      cnt_reg;

    assign full    = (cnt_reg == (PW+1)'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_sum = mem[rp_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == PW'(QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == PW'(QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_sum;
    end

endmodule

// ----- hw/rtl/gdc_back.sv -----
// ----------------------------------------------------------------------------
// gdc_back
// Turns a trajectory sum into its cost: gate test, mean by a reciprocal
// multiply, weight and power by a shared multiplier over partial products.
// ----------------------------------------------------------------------------
module gdc_back
    import gdc_pkg::*;
#(
    parameter int STEPS = STEPS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  logic [SUM_W-1:0]  q_sum,
    output logic              pop,
    input  logic              critic_enabled,
    input  logic [POS_W-1:0]  goal_x,
    input  logic [POS_W-1:0]  goal_y,
    input  logic [POS_W-1:0]  robot_x,
    input  logic [POS_W-1:0]  robot_y,
    input  logic [POS_W-1:0]  weight_q,
    input  logic [POW_W-1:0]  pow_exp,
    input  logic [POS_W-1:0]  consider_radius,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [COST_W-1:0] cost_add,
    output logic              gated_off
);

    // exact division by STEPS for sums below 2^SUM_W: floor(n * recip / 2^RK)
    localparam int STEP_LOG = $clog2(STEPS);
    localparam int RK       = SUM_W + STEP_LOG;
    localparam logic [63:0] MEAN_RECIP =
        ((64'd1 << RK) + 64'(STEPS) - 64'd1) / 64'(STEPS);

    back_state_t state_reg, state_next;

    logic [SUM_W-1:0]    num_reg;
    logic [2:0]          qk_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [2*DIFF_W-1:0] p_reg;
    logic [1:0]          sh_reg;
    logic [COST_W-1:0]   a_reg, b_reg, wm_reg, cost_reg;
    logic                mdone_reg, wdone_reg, gated_reg;
    logic [POW_W-1:0]    pw_reg;
    logic                ov_reg;
    logic [COST_W-1:0]   oc_reg;
    logic                og_reg;

    logic [DIFF_W-1:0]   ma, mb, rdx, rdy;
    logic [2*DIFF_W-1:0] prod;
    logic [ACC_W-1:0]    p_shift;
    logic [COST_W-1:0]   q_res;
    logic                out_free;

    assign rdx      = abs_diff(robot_x, goal_x);
    assign rdy      = abs_diff(robot_y, goal_y);
    assign out_free = !ov_reg || out_ready;
    assign q_res    = (|acc_reg[ACC_W-1:79]) ? {COST_W{1'b1}} : acc_reg[78:16];

    // shared multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            B_G0: begin ma = rdx; mb = rdx; end
            B_G1: begin ma = rdy; mb = rdy; end
            B_G2: begin ma = DIFF_W'(consider_radius); mb = DIFF_W'(consider_radius); end
            B_QM:
            begin
                ma = qk_reg[1] ? DIFF_W'(a_reg[COST_W-1:32]) : DIFF_W'(a_reg[31:0]);
                mb = qk_reg[0] ? DIFF_W'(b_reg[COST_W-1:32]) : DIFF_W'(b_reg[31:0]);
            end
            default: ;
        endcase
    end

    assign prod = ma * mb;

    // registered partial product placed by its weight
    always_comb
    begin
        unique case (sh_reg)
            2'd0:    p_shift = ACC_W'(p_reg);
            2'd1:    p_shift = ACC_W'(p_reg) << 32;
            default: p_shift = ACC_W'(p_reg) << 64;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!q_empty) state_next = B_G0;
            B_G0:   state_next = B_G1;
            B_G1:   state_next = B_G2;
            B_G2:   state_next = B_G3;
            B_G3:
            begin
                if (!critic_enabled || !(acc_reg[SQ_W-1:0] < SQ_W'(p_reg)))
                    state_next = B_OUT;
                else
                    state_next = B_QM;
            end
            B_QM:   if (qk_reg == 3'd4) state_next = B_QEND;
            B_QEND: state_next = mdone_reg ? B_POW : B_QM;
            B_POW:  state_next = (pw_reg == pow_exp) ? B_OUT : B_QM;
            B_OUT:  if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop       = (state_reg == B_IDLE) && !q_empty;
        out_valid = ov_reg;
        cost_add  = oc_reg;
        gated_off = og_reg;
    end

    // control and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_OUT && out_free)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        p_reg <= prod;
        unique case (state_reg)
            B_IDLE:
            begin
                num_reg <= q_sum;
                sh_reg  <= 2'd0;
            end
            B_G0: ;
            B_G1: acc_reg <= ACC_W'(p_reg);
            B_G2: acc_reg <= acc_reg + ACC_W'(p_reg);
            B_G3:
            begin
                gated_reg <= !critic_enabled || !(acc_reg[SQ_W-1:0] < SQ_W'(p_reg));
                cost_reg  <= '0;
                // mean as sum times the reciprocal of STEPS
                a_reg     <= COST_W'(num_reg);
                b_reg     <= COST_W'(MEAN_RECIP);
                qk_reg    <= '0;
                acc_reg   <= '0;
                mdone_reg <= 1'b0;
                wdone_reg <= 1'b0;
            end
            B_QM:
            begin
                qk_reg <= qk_reg + 1'b1;
                // weight of the product that lands in p_reg next cycle
                sh_reg <= (qk_reg == 3'd0) ? 2'd0 : (qk_reg == 3'd3) ? 2'd2 : 2'd1;
                if (qk_reg != 3'd0)
                    acc_reg <= acc_reg + p_shift;
            end
            B_QEND:
            begin
                if (!mdone_reg)
                begin
                    a_reg     <= COST_W'(acc_reg[RK +: SUM_W]);
                    b_reg     <= COST_W'(weight_q);
                    qk_reg    <= '0;
                    acc_reg   <= '0;
                    mdone_reg <= 1'b1;
                end
                else if (!wdone_reg)
                begin
                    wm_reg    <= q_res;
                    cost_reg  <= COST_ONE;
                    pw_reg    <= '0;
                    wdone_reg <= 1'b1;
                end
                else
                begin
                    cost_reg <= q_res;
                    pw_reg   <= pw_reg + 1'b1;
                end
            end
            B_POW:
            begin
                a_reg   <= cost_reg;
                b_reg   <= wm_reg;
                qk_reg  <= '0;
                sh_reg  <= 2'd0;
                acc_reg <= '0;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    oc_reg <= gated_reg ? '0 : cost_reg;
                    og_reg <= gated_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- hw/rtl/goal_distance_trajectory_cost.sv -----
// ----------------------------------------------------------------------------
// goal_distance_trajectory_cost
// Mean distance-to-goal cost per sampled trajectory, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one trajectory point per beat (x low, y high, Q16.16).
//   Every STEPS points close a trajectory and give one beat on m_*:
//   the saturating cost contribution in m_tdata and the gate flag in
//   m_tuser. cfg_we/cfg_addr/cfg_wdata write the registers, one per cycle.
//   The user must write them only while the block is idle; the block
//   itself does not enforce this. The front takes a new point only after
//   the last one has passed difference, squares, sum, the 35 steps of the
//   bit-serial square root and accumulate.
//   The back works through gate, mean by reciprocal multiply and weight,
//   then each power step; it overlaps the next trajectory's points
//   through a two-entry sum queue.
//   Reset clears counters, sum, queue and output valid, and loads the
//   register defaults (enabled, weight 5.0, power 1, radius 1.4).
//   A stalled receiver holds the result beat; the back takes one more
//   result, then the queue fills and finally s_tready drops.
// ----------------------------------------------------------------------------
module goal_distance_trajectory_cost
    import gdc_pkg::*;
#(
    parameter int STEPS = STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] point_x, [63:32] point_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [62:0] cost_add, [63] zero
    output logic        m_tuser,   // [0] gated_off
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    logic             en_reg;
    logic [POS_W-1:0] gx_reg, gy_reg, rx_reg, ry_reg, w_reg, rad_reg;
    logic [POW_W-1:0] pow_reg;

    logic             push, pop, q_full, q_empty;
    logic [SUM_W-1:0] push_sum, pop_sum;
    logic [COST_W-1:0] cost_add;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg  <= 1'b1;
            gx_reg  <= '0;
            gy_reg  <= '0;
            rx_reg  <= '0;
            ry_reg  <= '0;
            w_reg   <= POS_W'(327680);
            pow_reg <= POW_W'(1);
            rad_reg <= POS_W'(91750);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_ENABLE:  en_reg  <= cfg_wdata[0];
                REG_GOAL_X:  gx_reg  <= cfg_wdata;
                REG_GOAL_Y:  gy_reg  <= cfg_wdata;
                REG_ROBOT_X: rx_reg  <= cfg_wdata;
                REG_ROBOT_Y: ry_reg  <= cfg_wdata;
                REG_WEIGHT:  w_reg   <= cfg_wdata;
                REG_POWER:   pow_reg <= cfg_wdata[POW_W-1:0];
                REG_RADIUS:  rad_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // point front
    gdc_front #(.STEPS(STEPS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .point_x  (s_tdata[31:0]),
        .point_y  (s_tdata[63:32]),
        .goal_x   (gx_reg),
        .goal_y   (gy_reg),
        .push     (push),
        .push_sum (push_sum),
        .q_full   (q_full)
    );

    // sum queue
    gdc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_sum (push_sum),
        .full     (q_full),
        .pop      (pop),
        .pop_sum  (pop_sum),
        .empty    (q_empty)
    );

    // cost back end
    gdc_back #(.STEPS(STEPS)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_sum           (pop_sum),
        .pop             (pop),
        .critic_enabled  (en_reg),
        .goal_x          (gx_reg),
        .goal_y          (gy_reg),
        .robot_x         (rx_reg),
        .robot_y         (ry_reg),
        .weight_q        (w_reg),
        .pow_exp         (pow_reg),
        .consider_radius (rad_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .cost_add        (cost_add),
        .gated_off       (m_tuser)
    );

    assign m_tdata = {1'b0, cost_add};

endmodule
